FILE: src/whrs_pkg.sv
// Shared types, codes and helpers of the weighted hop rate selector.
package whrs_pkg;

  localparam int RATE_W  = 32;
  localparam int FACT_W  = 24;
  localparam int TOTAL_W = 40;
  localparam int FRAC_W  = 32;
  localparam int IDX_W   = 8;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_HEAD_PLUS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_MINUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_PLUS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_MINUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COOP       = 3'd4;

  localparam logic [RATE_W-1:0] RATE_RESET = 32'h0001_0000;
  localparam logic [FACT_W-1:0] FACT_RESET = 24'h01_0000;

  typedef struct packed {
    logic              command;
    logic              restart_list;
    logic              terminus;
    logic              direction;
    logic              away_from_neighbour;
    logic [FRAC_W-1:0] uniform_fraction;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total_rate;
    logic [IDX_W-1:0]   chosen_index;
    logic [STAT_W-1:0]  status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_APPEND,
    ST_THR_LO,
    ST_THR_HI,
    ST_WALK,
    ST_OUT
  } state_t;

  // Saturating add of a rate into a 40-bit sum.
  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [RATE_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

endpackage

FILE: src/whrs_cell.sv
// One storage cell of the candidate rate ring.
module whrs_cell
  import whrs_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [RATE_W-1:0] wr_data,
  input  logic              shift_en,
  input  logic [RATE_W-1:0] shift_in,
  output logic [RATE_W-1:0] rate
);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rate <= wr_data;
    end else if (shift_en) begin
      rate <= shift_in;
    end
  end

endmodule

FILE: src/weighted_hop_rate_selector_unit.sv
// Top level of the weighted hop rate selector: control, arithmetic and cell ring.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_data (in_item_t)
//   out      output     out_valid/out_stall out_data (out_item_t)
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// An append passes through the product register, then the store, then the output state.
// In a select the cell ring rotates once all the way round past the prefix accumulator,
// so order is restored; an empty select or a zero total goes straight to the output state.
// Reset clears count, total and handshake, presets config regs; cells need no reset.
// A new item is taken only once the previous one has been handed to the output
// register; a stalled output holds the block in its final state.
module weighted_hop_rate_selector_unit
  import whrs_pkg::*;
#(
  parameter int MAX_CANDIDATES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]    cfg_data
);

  localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
  localparam int POS_W = $clog2(MAX_CANDIDATES);

  state_t state, state_next;

  logic [RATE_W-1:0]  head_plus, head_minus, tail_plus, tail_minus;
  logic [FACT_W-1:0]  coop;
  logic [CNT_W-1:0]   count;
  logic [TOTAL_W-1:0] total;

  in_item_t                   item;
  logic [RATE_W+FACT_W-1:0]   prod;
  logic [2*FRAC_W-1:0]        prod_lo;
  logic [TOTAL_W-1:0]         threshold;
  logic [TOTAL_W-1:0]         prefix;
  logic [POS_W-1:0]           pos;
  logic [POS_W-1:0]           chosen;
  logic                       found;
  logic                       appended;
  logic                       in_accept;
  logic                       out_free;
  logic                       full;
  logic                       cell_wr;
  logic                       walk;
  logic [RATE_W-1:0]          base;
  logic [RATE_W-1:0]          new_rate;
  logic [TOTAL_W-1:0]         prefix_next;
  logic                       last_pos;
  logic [RATE_W-1:0]          cell_rate [MAX_CANDIDATES];

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign full      = (count == CNT_W'(MAX_CANDIDATES));
  assign cfg_ready = 1'b1;
  assign last_pos  = (pos == POS_W'(MAX_CANDIDATES - 1));

  always_comb begin
    case ({item.terminus, item.direction})
      2'b00:   base = head_plus;
      2'b01:   base = head_minus;
      2'b10:   base = tail_plus;
      default: base = tail_minus;
    endcase
  end

  // Shifting the Q24.32 product back to Q16.16 leaves 40 bits; the top 8 saturate.
  always_comb begin
    if (!item.away_from_neighbour) begin
      new_rate = base;
    end else if (prod[RATE_W+FACT_W-1:RATE_W+16] != '0) begin
      new_rate = {RATE_W{1'b1}};
    end else begin
      new_rate = prod[RATE_W+15:16];
    end
  end

  assign prefix_next = sat_add(prefix, cell_rate[0]);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data.command == CMD_APPEND) begin
            state_next = ST_MUL;
          end else if (count == '0 || total == '0) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_THR_LO;
          end
        end
      end
      ST_MUL:    state_next = ST_APPEND;
      ST_APPEND: state_next = ST_OUT;
      ST_THR_LO: state_next = ST_THR_HI;
      ST_THR_HI: state_next = ST_WALK;
      ST_WALK:   state_next = last_pos ? ST_OUT : ST_WALK;
      ST_OUT:    state_next = out_free ? ST_IDLE : ST_OUT;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    cell_wr  = (state == ST_APPEND) && !full;
    walk     = (state == ST_WALK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_plus  <= RATE_RESET;
      head_minus <= RATE_RESET;
      tail_plus  <= RATE_RESET;
      tail_minus <= RATE_RESET;
      coop       <= FACT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEAD_PLUS:  head_plus  <= cfg_data;
        REG_HEAD_MINUS: head_minus <= cfg_data;
        REG_TAIL_PLUS:  tail_plus  <= cfg_data;
        REG_TAIL_MINUS: tail_minus <= cfg_data;
        REG_COOP:       coop       <= cfg_data[FACT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
      found <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          found <= 1'b0;
          if (in_accept && in_data.command == CMD_APPEND && in_data.restart_list) begin
            count <= '0;
            total <= '0;
          end
        end
        ST_APPEND: begin
          if (!full) begin
            count <= count + 1'b1;
            total <= sat_add(total, new_rate);
          end
        end
        ST_WALK: begin
          if (!found && (CNT_W'(pos) < count) && prefix_next > threshold) begin
            found <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          item <= in_data;
        end
        pos    <= '0;
        prefix <= '0;
        chosen <= '0;
      end
      ST_MUL:    prod    <= base * coop;
      ST_THR_LO: prod_lo <= total[FRAC_W-1:0] * item.uniform_fraction;
      ST_THR_HI: begin
        threshold <= TOTAL_W'(total[TOTAL_W-1:FRAC_W] * item.uniform_fraction)
                   + TOTAL_W'(prod_lo[2*FRAC_W-1:FRAC_W]);
      end
      ST_WALK: begin
        prefix <= prefix_next;
        pos    <= pos + 1'b1;
        if (!found && (CNT_W'(pos) < count) && prefix_next > threshold) begin
          chosen <= pos;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_data.total_rate <= total;
      if (item.command == CMD_APPEND) begin
        out_data.status       <= appended ? STAT_OK : STAT_FULL;
        out_data.chosen_index <= '0;
      end else if (found) begin
        out_data.status       <= STAT_OK;
        out_data.chosen_index <= IDX_W'(chosen);
      end else begin
        out_data.status       <= STAT_EMPTY;
        out_data.chosen_index <= '0;
      end
    end
  end

  // Marks whether the current append stored its rate.
  always_ff @(posedge clk) begin
    if (rst) begin
      appended <= 1'b0;
    end else if (state == ST_IDLE) begin
      appended <= 1'b0;
    end else if (cell_wr) begin
      appended <= 1'b1;
    end
  end

  for (genvar i = 0; i < MAX_CANDIDATES; i++) begin : g_cell
    whrs_cell u_cell (
      .clk      (clk),
      .wr_en    (cell_wr && count == CNT_W'(i)),
      .wr_data  (new_rate),
      .shift_en (walk),
      .shift_in (cell_rate[(i + 1) % MAX_CANDIDATES]),
      .rate     (cell_rate[i])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_CANDIDATES))
    else $error("candidate count beyond capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while one is in progress");

  a_index_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STAT_OK |-> out_data.chosen_index == '0)
    else $error("nonzero index with a failing status");

endmodule
